// ===== hdl/cdq_pkg.sv =====
// shared types, codes and defaults for the circular deque
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 8;
    localparam int CAP_RST   = 128;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_FRONT,
        S_RD_REAR,
        S_CAPTURE,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RD_POP,
        RD_FRONT,
        RD_REAR
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        logic    exec;
        logic    cap_pop;
        logic    cap_front;
        logic    cap_rear;
        rd_sel_t rd_sel;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cdq_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/cdq_ctrl.sv =====
// controller state machine sequencing one deque transaction
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output cdq_pkg::cmd_t      cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;
    logic            accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = cdq_pkg::S_EXEC;
                end
            end
            cdq_pkg::S_EXEC:     state_next = cdq_pkg::S_RD_FRONT;
            cdq_pkg::S_RD_FRONT: state_next = cdq_pkg::S_RD_REAR;
            cdq_pkg::S_RD_REAR:  state_next = cdq_pkg::S_CAPTURE;
            cdq_pkg::S_CAPTURE:  state_next = cdq_pkg::S_RESP;
            cdq_pkg::S_RESP:     state_next = cdq_pkg::S_IDLE;
            default:             state_next = cdq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        done          = 1'b0;
        cmd.latch     = 1'b0;
        cmd.exec      = 1'b0;
        cmd.cap_pop   = 1'b0;
        cmd.cap_front = 1'b0;
        cmd.cap_rear  = 1'b0;
        cmd.rd_sel    = cdq_pkg::RD_POP;
        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            cdq_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                cmd.rd_sel = cdq_pkg::RD_POP;
            end
            cdq_pkg::S_RD_FRONT:
            begin
                cmd.cap_pop = 1'b1;
                cmd.rd_sel  = cdq_pkg::RD_FRONT;
            end
            cdq_pkg::S_RD_REAR:
            begin
                cmd.cap_front = 1'b1;
                cmd.rd_sel    = cdq_pkg::RD_REAR;
            end
            cdq_pkg::S_CAPTURE:
            begin
                cmd.cap_rear = 1'b1;
            end
            cdq_pkg::S_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // every accepted transaction answers after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("result strobe missing after accepted transaction");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ===== hdl/cdq_datapath.sv =====
// deque datapath: indices, capacity, ring storage and result registers
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire cdq_pkg::cmd_t                          cmd,
    input  wire logic        [cdq_pkg::OP_W-1:0]        opcode,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]      data_in,
    input  wire logic                                   cfg_we,
    input  wire logic        [cdq_pkg::CFG_W-1:0]       cfg_data,
    output logic             [cdq_pkg::STATUS_W-1:0]    status,
    output logic signed      [cdq_pkg::DATA_W-1:0]      popped_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]      front_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]      rear_value,
    output logic                                        is_empty,
    output logic                                        is_full
);

    localparam int IW      = $clog2(DEPTH);
    localparam int CAPW    = IW + 1;
    localparam int CAP_RST = (cdq_pkg::CAP_RST > DEPTH) ? DEPTH : cdq_pkg::CAP_RST;

    logic [IW-1:0]   front_reg;
    logic [IW-1:0]   front_next;
    logic [IW-1:0]   rear_reg;
    logic [IW-1:0]   rear_next;
    logic            empty_reg;
    logic            empty_next;
    logic [CAPW-1:0] cap_reg;
    logic [CAPW-1:0] cap_next;

    logic [cdq_pkg::OP_W-1:0]     op_reg;
    logic [cdq_pkg::DATA_W-1:0]   din_reg;
    logic                         pop_ok_reg;
    logic [cdq_pkg::STATUS_W-1:0] status_reg;
    logic [cdq_pkg::STATUS_W-1:0] status_next;
    logic [cdq_pkg::DATA_W-1:0]   popped_reg;
    logic [cdq_pkg::DATA_W-1:0]   front_val_reg;
    logic [cdq_pkg::DATA_W-1:0]   rear_val_reg;
    logic                         empty_out_reg;
    logic                         full_out_reg;

    logic [CAPW-1:0] cap_m1;
    logic [CAPW-1:0] front_inc_w;
    logic [CAPW-1:0] rear_inc_w;
    logic [IW-1:0]   front_inc;
    logic [IW-1:0]   front_dec;
    logic [IW-1:0]   rear_inc;
    logic [IW-1:0]   rear_dec;
    logic            full_now;
    logic [31:0]     cfg_ext;
    logic [31:0]     cfg_sat;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [IW-1:0]              ram_raddr;
    logic [cdq_pkg::DATA_W-1:0] ram_rdata;
    logic                       is_push;
    logic                       is_pop;
    logic                       pop_ok_next;

    // ring index stepping with wrap at the capacity
    assign cap_m1      = cap_reg - 1'b1;
    assign front_inc_w = {1'b0, front_reg} + 1'b1;
    assign rear_inc_w  = {1'b0, rear_reg} + 1'b1;
    assign front_inc   = (front_inc_w >= cap_reg) ? '0 : front_inc_w[IW-1:0];
    assign rear_inc    = (rear_inc_w >= cap_reg) ? '0 : rear_inc_w[IW-1:0];
    assign front_dec   = (front_reg == '0) ? cap_m1[IW-1:0] : front_reg - 1'b1;
    assign rear_dec    = (rear_reg == '0) ? cap_m1[IW-1:0] : rear_reg - 1'b1;
    assign full_now    = !empty_reg && (rear_inc == front_reg);

    // capacity saturates to one and to the ring depth
    assign cfg_ext  = 32'(cfg_data);
    assign cfg_sat  = (cfg_ext == 32'd0) ? 32'd1 :
                      (cfg_ext > 32'(DEPTH)) ? 32'(DEPTH) : cfg_ext;
    assign cap_next = cfg_sat[CAPW-1:0];

    always_comb
    begin
        is_push = 1'b0;
        is_pop  = 1'b0;
        unique case (op_reg) inside
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: is_push = 1'b1;
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:   is_pop  = 1'b1;
            default:                                       is_push = 1'b0;
        endcase
    end

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = cdq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        if (cfg_we)
        begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
        end
        else if (cmd.exec)
        begin
            if (is_push)
            begin
                if (full_now)
                begin
                    status_next = cdq_pkg::ST_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                end
                else if (op_reg == cdq_pkg::OP_PUSH_FRONT)
                begin
                    front_next = front_dec;
                    ram_we     = 1'b1;
                    ram_waddr  = front_dec;
                end
                else
                begin
                    rear_next = rear_inc;
                    ram_we    = 1'b1;
                    ram_waddr = rear_inc;
                end
            end
            else if (is_pop)
            begin
                if (empty_reg)
                begin
                    status_next = cdq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    if (front_reg == rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (op_reg == cdq_pkg::OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                    end
                    else
                    begin
                        rear_next = rear_dec;
                    end
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            cdq_pkg::RD_POP:   ram_raddr = (op_reg == cdq_pkg::OP_POP_FRONT) ? front_reg
                                                                             : rear_reg;
            cdq_pkg::RD_FRONT: ram_raddr = front_reg;
            cdq_pkg::RD_REAR:  ram_raddr = rear_reg;
            default:           ram_raddr = front_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= CAPW'(CAP_RST);
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            if (cfg_we)
            begin
                cap_reg <= cap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= opcode;
            din_reg <= data_in;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (cmd.cap_pop)
        begin
            popped_reg    <= pop_ok_reg ? ram_rdata : '0;
            empty_out_reg <= empty_reg;
            full_out_reg  <= full_now;
        end
        if (cmd.cap_front)
        begin
            front_val_reg <= empty_reg ? '0 : ram_rdata;
        end
        if (cmd.cap_rear)
        begin
            rear_val_reg <= empty_reg ? '0 : ram_rdata;
        end
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (din_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign front_value  = front_val_reg;
    assign rear_value   = rear_val_reg;
    assign is_empty     = empty_out_reg;
    assign is_full      = full_out_reg;

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, front_reg} < cap_reg) && ({1'b0, rear_reg} < cap_reg))
        else $error("ring index beyond capacity");

    a_empty_home: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (front_reg == '0) && (rear_reg == '0))
        else $error("empty deque with indices away from zero");

    a_cfg_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_we && ram_we))
        else $error("ring write during capacity update");

endmodule

`default_nettype wire

// ===== hdl/circular_deque.sv =====
// top level of the circular deque: controller, datapath and config port
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue in a ring of up to DEPTH entries. A transaction is taken
// when start is high and busy is low; its result appears on the result ports
// for exactly one cycle with done high, and a new transaction is taken only
// once the block is idle again after done. The single read port of the ring
// memory sets this pacing, since it serially reads the popped entry, the new
// front and the new rear. The receiver cannot stall results: done is never
// held. A capacity write (1 to DEPTH, saturated) is taken whenever the block
// is idle and empties the deque at once; no clearing pass follows reset.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [cdq_pkg::OP_W-1:0]      opcode,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    data_in,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [cdq_pkg::CFG_W-1:0]     cfg_data,
    output logic                                      done,
    output logic             [cdq_pkg::STATUS_W-1:0]  status,
    output logic signed      [cdq_pkg::DATA_W-1:0]    popped_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]    front_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]    rear_value,
    output logic                                      is_empty,
    output logic                                      is_full
);

    cdq_pkg::cmd_t cmd;
    logic          cfg_we;

    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    cdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .data_in      (data_in),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for circular_deque: directed and random deque transactions checked against a behavioral deque
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH = cdq_pkg::DEPTH_DEF;

    typedef enum int {GAP_NONE, GAP_RANDOM, GAP_RARE} gap_mode_t;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct {
        logic [cdq_pkg::OP_W-1:0]   op;
        logic [cdq_pkg::DATA_W-1:0] data;
        int                         gap;
    } deque_op_t;

    typedef struct {
        logic [cdq_pkg::STATUS_W-1:0] status;
        logic [cdq_pkg::DATA_W-1:0]   popped;
        logic [cdq_pkg::DATA_W-1:0]   front;
        logic [cdq_pkg::DATA_W-1:0]   rear;
        logic                         empty;
        logic                         full;
    } deque_reply_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic        [cdq_pkg::OP_W-1:0]     opcode = cdq_pkg::OP_PEEK;
    logic signed [cdq_pkg::DATA_W-1:0]   data_in = '0;
    logic                                cfg_valid = 1'b0;
    logic        [cdq_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                                busy;
    logic                                cfg_ready;
    logic                                done;
    logic        [cdq_pkg::STATUS_W-1:0] status;
    logic signed [cdq_pkg::DATA_W-1:0]   popped_value;
    logic signed [cdq_pkg::DATA_W-1:0]   front_value;
    logic signed [cdq_pkg::DATA_W-1:0]   rear_value;
    logic                                is_empty;
    logic                                is_full;

    deque_op_t    op_queue[$];
    deque_reply_t predicted_results[$];
    int           error_count = 0;
    gap_mode_t    gap_mode = GAP_RANDOM;

    // behavioral deque
    logic [cdq_pkg::DATA_W-1:0] ring_model [DEPTH];
    int unsigned                head_idx = 0;
    int unsigned                tail_idx = 0;
    int unsigned                cap_model = cdq_pkg::CAP_RST;
    bit                         empty_model = 1'b1;

    deque_op_t    drv_next;
    int           drv_wait = 0;
    int           drv_gap = 0;
    deque_reply_t mon_want;

    circular_deque #(.DEPTH(DEPTH)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data_in      (data_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit model_full();
        int unsigned nxt;
        if (empty_model)
            return 1'b0;
        nxt = (tail_idx + 1 >= cap_model) ? 0 : tail_idx + 1;
        return nxt == head_idx;
    endfunction

    function automatic void model_clear();
        head_idx = 0;
        tail_idx = 0;
        empty_model = 1'b1;
    endfunction

    function automatic void model_set_capacity(logic [cdq_pkg::CFG_W-1:0] value);
        int unsigned v;
        v = value;
        if (v < 1)
            v = 1;
        if (v > DEPTH)
            v = DEPTH;
        cap_model = v;
        model_clear();
    endfunction

    function automatic deque_reply_t deque_predict(logic [cdq_pkg::OP_W-1:0]   op,
                                                   logic [cdq_pkg::DATA_W-1:0] value);
        deque_reply_t r;
        r.status = cdq_pkg::ST_OK;
        r.popped = '0;
        if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR)
        begin
            if (model_full())
                r.status = cdq_pkg::ST_OVERFLOW;
            else if (empty_model)
            begin
                head_idx = 0;
                tail_idx = 0;
                empty_model = 1'b0;
                ring_model[0] = value;
            end
            else if (op == cdq_pkg::OP_PUSH_FRONT)
            begin
                head_idx = (head_idx == 0) ? cap_model - 1 : head_idx - 1;
                ring_model[head_idx] = value;
            end
            else
            begin
                tail_idx = (tail_idx + 1 >= cap_model) ? 0 : tail_idx + 1;
                ring_model[tail_idx] = value;
            end
        end
        else if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_REAR)
        begin
            if (empty_model)
                r.status = cdq_pkg::ST_UNDERFLOW;
            else if (op == cdq_pkg::OP_POP_FRONT)
            begin
                r.popped = ring_model[head_idx];
                if (head_idx == tail_idx)
                    model_clear();
                else
                    head_idx = (head_idx + 1 >= cap_model) ? 0 : head_idx + 1;
            end
            else
            begin
                r.popped = ring_model[tail_idx];
                if (head_idx == tail_idx)
                    model_clear();
                else
                    tail_idx = (tail_idx == 0) ? cap_model - 1 : tail_idx - 1;
            end
        end
        r.front = empty_model ? '0 : ring_model[head_idx];
        r.rear  = empty_model ? '0 : ring_model[tail_idx];
        r.empty = empty_model;
        r.full  = model_full();
        return r;
    endfunction

    task automatic report_error(string msg);
        if (error_count < 100)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [cdq_pkg::DATA_W-1:0] got,
                               logic [cdq_pkg::DATA_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s mismatch: got %h want %h", name, got, want));
    endtask

    function automatic int draw_gap();
        case (gap_mode)
            GAP_NONE:   return 0;
            GAP_RARE:   return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13) : 0;
            default:    return $urandom_range(0, 13);
        endcase
    endfunction

    function automatic logic [cdq_pkg::DATA_W-1:0] draw_data();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic add_op(logic [cdq_pkg::OP_W-1:0] code, logic [cdq_pkg::DATA_W-1:0] value);
        op_queue.push_back('{code, value, draw_gap()});
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (op_queue.size() != 0 || predicted_results.size() != 0 || start)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [cdq_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_set_capacity(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count, gap_mode_t gm);
        int                       left;
        int                       burst;
        int                       push_pct;
        int                       pop_pct;
        int unsigned              roll;
        mix_t                     mix;
        logic [cdq_pkg::OP_W-1:0] op;
        gap_mode = gm;
        left = count;
        while (left > 0)
        begin
            mix = mix_t'($urandom_range(0, 2));
            push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 10 : 45;
            pop_pct  = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 85 : 45;
            burst = $urandom_range(1, 2 * cap_model + 4);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
                else if (roll < push_pct + pop_pct)
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
                else
                    op = cdq_pkg::OP_PEEK + 3'($urandom_range(0, 3));
                add_op(op, draw_data());
            end
            left -= burst;
        end
    endtask

    // driver: one transaction in flight, gap counted from acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            opcode   <= cdq_pkg::OP_PEEK;
            data_in  <= '0;
            drv_wait = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_results.push_back(deque_predict(opcode, data_in));
                drv_wait = drv_gap;
            end
            if (start && busy)
            begin
            end
            else if (drv_wait > 0)
            begin
                drv_wait--;
                start <= 1'b0;
            end
            else if (op_queue.size() > 0)
            begin
                drv_next = op_queue.pop_front();
                start   <= 1'b1;
                opcode  <= drv_next.op;
                data_in <= drv_next.data;
                drv_gap = drv_next.gap;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
                report_error($sformatf("unexpected result: status %0d popped %h",
                                       status, popped_value));
            else
            begin
                mon_want = predicted_results.pop_front();
                check_field("status", 32'(status), 32'(mon_want.status));
                check_field("popped_value", popped_value, mon_want.popped);
                check_field("front_value", front_value, mon_want.front);
                check_field("rear_value", rear_value, mon_want.rear);
                check_field("is_empty", 32'(is_empty), 32'(mon_want.empty));
                check_field("is_full", 32'(is_full), 32'(mon_want.full));
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset capacity: empty ops, unused opcodes, extremes, pop down to empty
        gap_mode = GAP_RANDOM;
        add_op(cdq_pkg::OP_POP_FRONT, 32'h1111_1111);
        add_op(cdq_pkg::OP_POP_REAR, 32'h2222_2222);
        add_op(cdq_pkg::OP_PEEK, 32'h0);
        add_op(cdq_pkg::OP_PEEK + 3'd1, 32'hffff_ffff);
        add_op(cdq_pkg::OP_PEEK + 3'd2, 32'h0);
        add_op(cdq_pkg::OP_PEEK + 3'd3, 32'h5555_5555);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'h7fff_ffff);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'h0000_0000);
        add_op(cdq_pkg::OP_PEEK, 32'h0);
        add_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        add_op(cdq_pkg::OP_POP_REAR, 32'h0);
        add_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        add_op(cdq_pkg::OP_POP_REAR, 32'h0);
        add_op(cdq_pkg::OP_POP_REAR, 32'h0);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'hdead_beef);

        // single entry ring, written while the deque holds entries
        write_capacity(8'd1);
        gap_mode = GAP_NONE;
        add_op(cdq_pkg::OP_PEEK, 32'h0);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'hcafe_f00d);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'h0bad_0bad);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'h0f0f_0f0f);
        add_op(cdq_pkg::OP_POP_REAR, 32'h0);
        add_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'ha5a5_a5a5);

        write_capacity(8'd0);
        random_phase(60, GAP_RANDOM);
        write_capacity(8'd2);
        random_phase(150, GAP_NONE);
        write_capacity(8'd3);
        random_phase(150, GAP_RANDOM);
        write_capacity(8'd255);
        random_phase(450, GAP_RARE);
        write_capacity(8'd128);
        random_phase(400, GAP_RANDOM);
        write_capacity(8'($urandom_range(1, DEPTH)));
        random_phase(100, GAP_RANDOM);
        write_capacity(8'($urandom_range(1, DEPTH)));
        random_phase(100, GAP_NONE);
        write_capacity(8'($urandom_range(1, DEPTH)));
        random_phase(100, GAP_RARE);
        write_capacity(8'd7);
        random_phase(150, GAP_RANDOM);
        write_capacity(8'd64);
        random_phase(250, GAP_RARE);

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
